// File: src/rgbl_pkg.sv
package rgbl_pkg;

	typedef enum logic [1:0] {
		CMD_SET  = 2'd0,
		CMD_READ = 2'd1,
		CMD_SEND = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_ACK  = 2'd0,
		KIND_READ = 2'd1,
		KIND_SPI  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		COL_G,
		COL_R,
		COL_B
	} color_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ONE,
		ST_G,
		ST_R,
		ST_B
	} state_t;

	typedef struct packed {
		logic   accept;
		logic   clr_we;
		logic   load_one;
		logic   load_pat;
		color_t sel;
	} ctl_t;

	typedef struct packed {
		logic clr_last;
		logic out_free;
	} sts_t;

	localparam logic [8:0] LED_COUNT_RST = 9'd4;
	localparam logic [7:0] SPI_ONE       = 8'h7E;
	localparam logic [7:0] SPI_ZERO      = 8'h70;
	localparam logic [7:0] BIT_TOP       = 8'h80;

	function automatic logic [63:0] encode_byte(input logic [7:0] v);
		logic [63:0] w;
		w = '0;
		for (int i = 0; i < 8; i++) begin
			w[8*i +: 8] = ((v << (7 - i)) & BIT_TOP) != 8'd0 ? SPI_ONE : SPI_ZERO;
		end
		return w;
	endfunction

endpackage

// File: src/rgb_led_chain_serializer_core.sv
// Addressable RGB LED chain serializer. Holds one red/green/blue byte per LED
// (MAX_LEDS entries in a single-port RAM) and answers three commands: set
// (one acknowledge), read (one result with the stored colours) and send
// (three 64-bit SPI pattern words, green, red, blue, each colour bit MSB first
// as byte 0x7E for one and 0x70 for zero). After reset the block zeroes all
// MAX_LEDS entries of the pixel RAM, one entry per cycle, and accepts no
// item until that pass ends; led_count writes are taken at any time. Items are
// handled one at a time: after accept a set or read passes through ST_ONE,
// a send reads the RAM and then loads green, red and blue in ST_G, ST_R and
// ST_B through the single output register; each such state waits while the
// output side stalls. An unused command code is accepted and dropped.
module rgb_led_chain_serializer_core
	import rgbl_pkg::*;
	#(
		parameter int MAX_LEDS = 256
	)
	(
		input  logic        clk,
		input  logic        arst_n,
		input  logic        cfg_we,
		input  logic [8:0]  cfg_data,
		input  logic        in_valid,
		output logic        in_ready,
		input  logic [1:0]  cmd,
		input  logic [15:0] led_index,
		input  logic [7:0]  red_in,
		input  logic [7:0]  green_in,
		input  logic [7:0]  blue_in,
		output logic        out_valid,
		input  logic        out_ready,
		output logic [1:0]  kind,
		output logic        status,
		output logic [7:0]  red_out,
		output logic [7:0]  green_out,
		output logic [7:0]  blue_out,
		output logic [63:0] spi_pattern,
		output logic        last,
		output logic        frame_end
	);

	ctl_t ctl;
	sts_t sts;

	rgbl_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.cmd     (cmd),
		.sts     (sts),
		.in_ready(in_ready),
		.ctl     (ctl)
	);

	rgbl_dp #(
		.MAX_LEDS(MAX_LEDS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.led_index  (led_index),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.ctl        (ctl),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.status     (status),
		.red_out    (red_out),
		.green_out  (green_out),
		.blue_out   (blue_out),
		.spi_pattern(spi_pattern),
		.last       (last),
		.frame_end  (frame_end)
	);

	a_send_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cmd == CMD_SEND |=> !in_ready)
		else $error("input taken during send");

	a_fend_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> last && kind == KIND_SPI)
		else $error("frame end off the blue word");

	a_pat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_SPI |-> spi_pattern == 64'd0 && !frame_end)
		else $error("pattern on non spi result");

	a_no_load_full: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.load_one || ctl.load_pat) |-> !out_valid || out_ready)
		else $error("result overwritten");

endmodule

// File: src/rgbl_ram.sv
module rgbl_ram
	#(
		parameter int WIDTH  = 24,
		parameter int DEPTH  = 256,
		parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
	)
	(
		input  logic              clk,
		input  logic              we,
		input  logic              re,
		input  logic [ADDR_W-1:0] addr,
		input  logic [WIDTH-1:0]  wdata,
		output logic [WIDTH-1:0]  rdata
	);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/rgbl_ctrl.sv
module rgbl_ctrl
	import rgbl_pkg::*;
	(
		input  logic       clk,
		input  logic       arst_n,
		input  logic       in_valid,
		input  logic [1:0] cmd,
		input  sts_t       sts,
		output logic       in_ready,
		output ctl_t       ctl
	);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		ctl.accept   = 1'b0;
		ctl.clr_we   = 1'b0;
		ctl.load_one = 1'b0;
		ctl.load_pat = 1'b0;
		ctl.sel      = COL_G;
		unique case (state_q)
			ST_CLEAR: begin
				ctl.clr_we = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready   = 1'b1;
				ctl.accept = in_valid;
				if (in_valid) begin
					unique case (cmd_t'(cmd))
						CMD_SET, CMD_READ: state_d = ST_ONE;
						CMD_SEND:          state_d = ST_G;
						default:           state_d = ST_IDLE;
					endcase
				end
			end
			ST_ONE: begin
				if (sts.out_free) begin
					ctl.load_one = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_G: begin
				ctl.sel = COL_G;
				if (sts.out_free) begin
					ctl.load_pat = 1'b1;
					state_d      = ST_R;
				end
			end
			ST_R: begin
				ctl.sel = COL_R;
				if (sts.out_free) begin
					ctl.load_pat = 1'b1;
					state_d      = ST_B;
				end
			end
			ST_B: begin
				ctl.sel = COL_B;
				if (sts.out_free) begin
					ctl.load_pat = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

endmodule

// File: src/rgbl_dp.sv
module rgbl_dp
	import rgbl_pkg::*;
	#(
		parameter int MAX_LEDS = 256
	)
	(
		input  logic        clk,
		input  logic        arst_n,
		input  logic        cfg_we,
		input  logic [8:0]  cfg_data,
		input  logic [1:0]  cmd,
		input  logic [15:0] led_index,
		input  logic [7:0]  red_in,
		input  logic [7:0]  green_in,
		input  logic [7:0]  blue_in,
		input  ctl_t        ctl,
		output sts_t        sts,
		output logic        out_valid,
		input  logic        out_ready,
		output logic [1:0]  kind,
		output logic        status,
		output logic [7:0]  red_out,
		output logic [7:0]  green_out,
		output logic [7:0]  blue_out,
		output logic [63:0] spi_pattern,
		output logic        last,
		output logic        frame_end
	);

	localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

	logic [8:0]    led_count_q;
	logic [AW-1:0] cursor_q;
	logic [AW-1:0] clr_q;
	logic [1:0]    kind_q;
	logic          bad_q;
	logic          fend_q;

	logic          out_valid_q;
	logic [1:0]    kind_o_q;
	logic          status_o_q;
	logic [23:0]   rgb_o_q;
	logic [63:0]   pat_o_q;
	logic          last_o_q;
	logic          fend_o_q;

	logic [16:0]   n_eff;
	logic [16:0]   span;
	logic          idx_ok;
	logic [AW-1:0] cur_eff;
	logic [16:0]   cur_next;
	logic          fend;
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [23:0]   ram_wdata;
	logic [23:0]   ram_rdata;
	logic [7:0]    pat_byte;
	logic [1:0]    item_kind;

	always_comb begin
		n_eff = ({8'd0, led_count_q} > 17'(MAX_LEDS)) ? 17'(MAX_LEDS) : {8'd0, led_count_q};
		span     = (n_eff == 17'd0) ? 17'd1 : n_eff;
		idx_ok   = {1'b0, led_index} < n_eff;
		cur_eff  = (17'(cursor_q) >= span) ? '0 : cursor_q;
		cur_next = 17'(cur_eff) + 17'd1;
		fend     = cur_next >= span;
	end

	always_comb begin
		unique case (cmd_t'(cmd))
			CMD_SET:  item_kind = KIND_ACK;
			CMD_READ: item_kind = KIND_READ;
			default:  item_kind = KIND_SPI;
		endcase
	end

	assign ram_we    = ctl.clr_we || (ctl.accept && cmd_t'(cmd) == CMD_SET && idx_ok);
	assign ram_wdata = ctl.clr_we ? 24'd0 : {red_in, green_in, blue_in};
	assign ram_addr  = ctl.clr_we ? clr_q :
		((cmd_t'(cmd) == CMD_SEND) ? cur_eff : led_index[AW-1:0]);

	rgbl_ram #(
		.WIDTH (24),
		.DEPTH (MAX_LEDS),
		.ADDR_W(AW)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.re   (ctl.accept),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_count_q <= LED_COUNT_RST;
			cursor_q    <= '0;
			clr_q       <= '0;
		end else begin
			if (cfg_we) begin
				led_count_q <= cfg_data;
			end
			if (ctl.clr_we) begin
				clr_q <= clr_q + AW'(1);
			end
			if (ctl.accept && cmd_t'(cmd) == CMD_SEND) begin
				cursor_q <= fend ? '0 : cur_next[AW-1:0];
			end
		end
	end

	assign sts.clr_last = (clr_q == AW'(MAX_LEDS - 1));
	assign sts.out_free = !out_valid_q || out_ready;

	// item context held across the result cycles
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			kind_q <= item_kind;
			bad_q  <= !idx_ok;
			fend_q <= fend;
		end
	end

	always_comb begin
		case (ctl.sel)
			COL_G:   pat_byte = ram_rdata[15:8];
			COL_R:   pat_byte = ram_rdata[23:16];
			default: pat_byte = ram_rdata[7:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_one || ctl.load_pat) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_one) begin
			kind_o_q   <= kind_q;
			status_o_q <= bad_q;
			rgb_o_q    <= (kind_q == KIND_READ && !bad_q) ? ram_rdata : 24'd0;
			pat_o_q    <= 64'd0;
			last_o_q   <= 1'b1;
			fend_o_q   <= 1'b0;
		end else if (ctl.load_pat) begin
			kind_o_q   <= KIND_SPI;
			status_o_q <= 1'b0;
			rgb_o_q    <= 24'd0;
			pat_o_q    <= encode_byte(pat_byte);
			last_o_q   <= (ctl.sel == COL_B);
			fend_o_q   <= (ctl.sel == COL_B) && fend_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_o_q;
	assign status      = status_o_q;
	assign red_out     = rgb_o_q[23:16];
	assign green_out   = rgb_o_q[15:8];
	assign blue_out    = rgb_o_q[7:0];
	assign spi_pattern = pat_o_q;
	assign last        = last_o_q;
	assign frame_end   = fend_o_q;

endmodule

// File: bench/tb_top.sv
module tb_top;
	import rgbl_pkg::*;

	typedef struct packed {
		cmd_t        op;
		logic [15:0] idx;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} led_item_t;

	typedef struct packed {
		kind_t       kind;
		logic        status;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [63:0] pattern;
		logic        last;
		logic        frame_end;
	} led_word_t;

	typedef struct packed {
		logic       is_cfg;
		logic [8:0] count;
		led_item_t  item;
		logic       typed;
		logic       status;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} script_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [8:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  cmd;
	logic [15:0] led_index;
	logic [7:0]  red_in;
	logic [7:0]  green_in;
	logic [7:0]  blue_in;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  kind;
	logic        status;
	logic [7:0]  red_out;
	logic [7:0]  green_out;
	logic [7:0]  blue_out;
	logic [63:0] spi_pattern;
	logic        last;
	logic        frame_end;

	logic [23:0] pixel_shadow [256];
	int          cursor_shadow;
	logic [8:0]  count_shadow;
	led_word_t   expected_words [$];
	int          mismatches = 0;
	logic        no_idle = 1'b0;

	rgb_led_chain_serializer_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.led_index  (led_index),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.status     (status),
		.red_out    (red_out),
		.green_out  (green_out),
		.blue_out   (blue_out),
		.spi_pattern(spi_pattern),
		.last       (last),
		.frame_end  (frame_end)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [63:0] spi_word(input logic [7:0] v);
		logic [63:0] w;
		w = '0;
		for (int i = 7; i >= 0; i--) w = {w[55:0], v[i] ? SPI_ONE : SPI_ZERO};
		return w;
	endfunction

	// expected results of one item go to the back of expected_words
	task automatic predict_leds(input led_item_t it);
		int          n;
		int          span;
		logic [23:0] px;
		led_word_t   w;
		n = (count_shadow > 9'd256) ? 256 : int'(count_shadow);
		w = '0;
		w.last = 1'b1;
		case (it.op)
			CMD_SET: begin
				w.kind = KIND_ACK;
				if (it.idx >= n) begin
					w.status = 1'b1;
				end else begin
					pixel_shadow[it.idx[7:0]] = {it.red, it.green, it.blue};
				end
				expected_words.push_back(w);
			end
			CMD_READ: begin
				w.kind = KIND_READ;
				if (it.idx >= n) begin
					w.status = 1'b1;
				end else begin
					px = pixel_shadow[it.idx[7:0]];
					{w.red, w.green, w.blue} = px;
				end
				expected_words.push_back(w);
			end
			CMD_SEND: begin
				span = (n == 0) ? 1 : n;
				if (cursor_shadow >= span) cursor_shadow = 0;
				px = pixel_shadow[cursor_shadow];
				w.kind = KIND_SPI;
				w.last = 1'b0;
				w.pattern = spi_word(px[15:8]);
				expected_words.push_back(w);
				w.pattern = spi_word(px[23:16]);
				expected_words.push_back(w);
				w.pattern = spi_word(px[7:0]);
				w.last = 1'b1;
				w.frame_end = (cursor_shadow + 1 >= span);
				expected_words.push_back(w);
				cursor_shadow = w.frame_end ? 0 : cursor_shadow + 1;
			end
			default: ;
		endcase
	endtask

	task automatic drive_item(input led_item_t it);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= it.op;
		led_index <= it.idx;
		red_in <= it.red;
		green_in <= it.green;
		blue_in <= it.blue;
		do @(posedge clk); while (in_ready !== 1'b1);
	endtask

	// wait for every expected item, then idle so that a dropped command drains
	task automatic settle_block();
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_count(input logic [8:0] v);
		settle_block();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		count_shadow = v;
	endtask

	function automatic script_row_t op_row(input cmd_t op, input logic [15:0] idx,
		input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		script_row_t row;
		row = '0;
		row.item = '{op: op, idx: idx, red: r, green: g, blue: b};
		return row;
	endfunction

	function automatic script_row_t check_row(input cmd_t op, input logic [15:0] idx,
		input logic [7:0] r, input logic [7:0] g, input logic [7:0] b, input logic st,
		input logic [7:0] er, input logic [7:0] eg, input logic [7:0] eb);
		script_row_t row;
		row = op_row(op, idx, r, g, b);
		row.typed = 1'b1;
		row.status = st;
		row.red = er;
		row.green = eg;
		row.blue = eb;
		return row;
	endfunction

	function automatic script_row_t count_row(input logic [8:0] v);
		script_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.count = v;
		return row;
	endfunction

	initial begin
		script_row_t rows [$];
		logic [8:0]  phase_counts [12];
		led_item_t   it;
		led_word_t   typed_w;
		int          n;
		int          pick;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = CMD_SET;
		led_index = '0;
		red_in = '0;
		green_in = '0;
		blue_in = '0;
		foreach (pixel_shadow[i]) pixel_shadow[i] = '0;
		cursor_shadow = 0;
		count_shadow = LED_COUNT_RST;

		rows.push_back(check_row(CMD_READ, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00));
		rows.push_back(check_row(CMD_READ, 16'd3, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00, 8'h00, 8'h00));
		rows.push_back(check_row(CMD_READ, 16'd4, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 8'h00, 8'h00));
		rows.push_back(check_row(CMD_SET, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b1,
			8'h00, 8'h00, 8'h00));
		rows.push_back(check_row(CMD_SET, 16'd0, 8'hFF, 8'h00, 8'hAA, 1'b0, 8'h00, 8'h00, 8'h00));
		rows.push_back(check_row(CMD_SET, 16'd3, 8'h00, 8'hFF, 8'h55, 1'b0, 8'h00, 8'h00, 8'h00));
		rows.push_back(check_row(CMD_READ, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0, 8'hFF, 8'h00, 8'hAA));
		rows.push_back(op_row(CMD_SEND, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
		rows.push_back(op_row(CMD_SEND, 16'h0000, 8'h00, 8'h00, 8'h00));
		rows.push_back(op_row(CMD_SEND, 16'hA5A5, 8'h5A, 8'hA5, 8'h0F));
		rows.push_back(op_row(CMD_SEND, 16'h5A5A, 8'hA5, 8'h5A, 8'hF0));
		rows.push_back(op_row(CMD_SEND, 16'd1, 8'h01, 8'h80, 8'h7F));
		rows.push_back(op_row(CMD_NONE, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
		// cursor sits at 1, past a one-led chain
		rows.push_back(count_row(9'd1));
		rows.push_back(op_row(CMD_SEND, 16'd0, 8'h00, 8'h00, 8'h00));
		rows.push_back(check_row(CMD_SET, 16'd1, 8'h12, 8'h34, 8'h56, 1'b1, 8'h00, 8'h00, 8'h00));
		rows.push_back(count_row(9'd0));
		rows.push_back(check_row(CMD_READ, 16'd0, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 8'h00, 8'h00));
		rows.push_back(op_row(CMD_SEND, 16'd0, 8'h00, 8'h00, 8'h00));
		rows.push_back(count_row(9'd511));
		rows.push_back(check_row(CMD_SET, 16'd255, 8'hFF, 8'hFF, 8'hFF, 1'b0,
			8'h00, 8'h00, 8'h00));
		rows.push_back(check_row(CMD_READ, 16'd255, 8'h00, 8'h00, 8'h00, 1'b0,
			8'hFF, 8'hFF, 8'hFF));
		rows.push_back(check_row(CMD_READ, 16'd256, 8'h00, 8'h00, 8'h00, 1'b1,
			8'h00, 8'h00, 8'h00));
		rows.push_back(op_row(CMD_SEND, 16'd0, 8'h00, 8'h00, 8'h00));
		rows.push_back(count_row(9'd256));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				write_count(rows[i].count);
			end else begin
				predict_leds(rows[i].item);
				if (rows[i].typed) begin
					typed_w = '0;
					typed_w.kind = (rows[i].item.op == CMD_SET) ? KIND_ACK : KIND_READ;
					typed_w.status = rows[i].status;
					typed_w.red = rows[i].red;
					typed_w.green = rows[i].green;
					typed_w.blue = rows[i].blue;
					typed_w.last = 1'b1;
					void'(expected_words.pop_back());
					expected_words.push_back(typed_w);
				end
				drive_item(rows[i].item);
			end
		end

		phase_counts = '{9'd1, 9'd256, 9'd0, 9'd511, 9'd257, 9'd8, 9'd3, 9'd2,
			9'd5, 9'd255, 9'd0, 9'd0};
		phase_counts[10] = 9'($urandom_range(1, 16));
		phase_counts[11] = 9'($urandom_range(0, 511));
		for (int ph = 0; ph < 12; ph++) begin
			write_count(phase_counts[ph]);
			no_idle = ($urandom_range(0, 3) == 0);
			n = (count_shadow > 9'd256) ? 256 : int'(count_shadow);
			for (int k = 0; k < 40; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 30) it.op = CMD_SET;
				else if (pick < 55) it.op = CMD_READ;
				else if (pick < 95) it.op = CMD_SEND;
				else it.op = CMD_NONE;
				pick = $urandom_range(0, 99);
				if (n > 0 && pick < 70) it.idx = 16'($urandom_range(0, n - 1));
				else if (pick < 85) it.idx = 16'(n + $urandom_range(0, 3));
				else it.idx = 16'($urandom_range(0, 65535));
				it.red = 8'($urandom_range(0, 255));
				it.green = 8'($urandom_range(0, 255));
				it.blue = 8'($urandom_range(0, 255));
				predict_leds(it);
				drive_item(it);
			end
		end

		settle_block();
		repeat (16) @(posedge clk);
		if (mismatches == 0 && expected_words.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		int        stall;
		led_word_t exp_w;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: kind %0d status %0d rgb %h %h %h spi %h",
						kind, status, red_out, green_out, blue_out, spi_pattern);
			end else begin
				exp_w = expected_words.pop_front();
				if (kind !== exp_w.kind || status !== exp_w.status ||
					red_out !== exp_w.red || green_out !== exp_w.green ||
					blue_out !== exp_w.blue || spi_pattern !== exp_w.pattern ||
					last !== exp_w.last || frame_end !== exp_w.frame_end) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch exp: kind %0d st %0d rgb %h %h %h spi %h last %0d fe %0d",
							exp_w.kind, exp_w.status, exp_w.red, exp_w.green, exp_w.blue,
							exp_w.pattern, exp_w.last, exp_w.frame_end);
						$display("         got: kind %0d st %0d rgb %h %h %h spi %h last %0d fe %0d",
							kind, status, red_out, green_out, blue_out, spi_pattern,
							last, frame_end);
					end
				end
			end
		end
	end

	initial begin
		#800000;
		$display("Verification failed");
		$finish;
	end

endmodule

// File: filelist.f
src/rgbl_pkg.sv
src/rgbl_ram.sv
src/rgbl_ctrl.sv
src/rgbl_dp.sv
src/rgb_led_chain_serializer_core.sv
bench/tb_top.sv
